[rtl/irnf_pkg.sv]
// Shared types and constants for the nearest-neighbor rotation fetch unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package irnf_pkg;

  // Frame geometry
  localparam int MAX_ROWS  = 512;
  localparam int MAX_COLS  = 512;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;

  // Register and pixel widths
  localparam int DIM_W  = 10;
  localparam int TRIG_W = 18;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;

  // Rotation arithmetic
  localparam int TRIG_FRAC_BITS = 16;
  localparam int OFF_W  = DIM_W + 1;
  localparam int PROD_W = TRIG_W + OFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SRC_W  = SUM_W - TRIG_FRAC_BITS + 1;

  // Queue between the front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TRIG_W;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN  = 2'd3;

  // Register reset values
  localparam logic [DIM_W-1:0]         ROWS_RESET = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0]         COLS_RESET = DIM_W'(MAX_COLS);
  localparam logic signed [TRIG_W-1:0] COS_RESET  = TRIG_W'(65536);
  localparam logic signed [TRIG_W-1:0] SIN_RESET  = TRIG_W'(0);

  // Operation codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // One classified operation waiting for the back end
  typedef struct packed {
    logic              func;
    logic              in_image;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } irnf_entry_t;

endpackage

[rtl/irnf_front.sv]
// Front end: accepts words, rotates fetch coordinates and classifies them.
// Four-stage pipeline feeding irnf_queue; uses irnf_pkg.
module irnf_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   func,
  input  logic [irnf_pkg::ROW_W-1:0]             row,
  input  logic [irnf_pkg::COL_W-1:0]             col,
  input  logic [irnf_pkg::CH_W-1:0]              pixel_blue,
  input  logic [irnf_pkg::CH_W-1:0]              pixel_green,
  input  logic [irnf_pkg::CH_W-1:0]              pixel_red,
  input  logic [irnf_pkg::DIM_W-1:0]             rows_in_use,
  input  logic [irnf_pkg::DIM_W-1:0]             cols_in_use,
  input  logic signed [irnf_pkg::TRIG_W-1:0]     cos_q,
  input  logic signed [irnf_pkg::TRIG_W-1:0]     sin_q,
  input  logic [irnf_pkg::QLVL_W-1:0]            q_level,
  output logic                                   push,
  output irnf_pkg::irnf_entry_t                  push_entry
);

  // Stage valids
  logic v1, v2, v3;

  // Stage 1: offsets from the center
  logic                                 func1, in1;
  logic [irnf_pkg::ROW_W-1:0]           row1;
  logic [irnf_pkg::COL_W-1:0]           col1;
  logic [irnf_pkg::PIX_W-1:0]           pix1;
  logic signed [irnf_pkg::OFF_W-1:0]    dr1, dc1;

  // Stage 2: products
  logic                                 func2, in2;
  logic [irnf_pkg::ROW_W-1:0]           row2;
  logic [irnf_pkg::COL_W-1:0]           col2;
  logic [irnf_pkg::PIX_W-1:0]           pix2;
  logic signed [irnf_pkg::PROD_W-1:0]   p_cr, p_sc, p_cc, p_sr;

  // Stage 3: product sums
  logic                                 func3, in3;
  logic [irnf_pkg::ROW_W-1:0]           row3;
  logic [irnf_pkg::COL_W-1:0]           col3;
  logic [irnf_pkg::PIX_W-1:0]           pix3;
  logic signed [irnf_pkg::SUM_W-1:0]    sum_r, sum_c;

  // Stage 4 combinational: truncate toward zero, re-center, range check
  logic                                 accept;
  logic [irnf_pkg::QLVL_W:0]            inflight;
  logic [irnf_pkg::DIM_W-1:0]           mr, mc;
  logic signed [irnf_pkg::OFF_W-1:0]    dr_next, dc_next;
  logic                                 in_next;
  logic                                 corr_r, corr_c;
  logic signed [irnf_pkg::SRC_W-1:0]    sr, sc;
  logic                                 src_ok;
  irnf_pkg::irnf_entry_t                entry_next;

  // Credit check: everything in flight must fit in the queue.
  assign inflight = (irnf_pkg::QLVL_W+1)'(v1) + (irnf_pkg::QLVL_W+1)'(v2)
                  + (irnf_pkg::QLVL_W+1)'(v3) + (irnf_pkg::QLVL_W+1)'(push);
  assign in_ready = ((irnf_pkg::QLVL_W+1)'(q_level) + inflight)
                    < (irnf_pkg::QLVL_W+1)'(irnf_pkg::QDEPTH);
  assign accept   = in_valid && in_ready;

  // Image center, halves truncated.
  assign mr = rows_in_use >> 1;
  assign mc = cols_in_use >> 1;

  assign dr_next = signed'(irnf_pkg::OFF_W'(row)) - signed'(irnf_pkg::OFF_W'(mr));
  assign dc_next = signed'(irnf_pkg::OFF_W'(col)) - signed'(irnf_pkg::OFF_W'(mc));
  assign in_next = (irnf_pkg::DIM_W'(row) < rows_in_use)
                && (irnf_pkg::DIM_W'(col) < cols_in_use);

  // A negative sum with a nonzero fraction rounds up by one toward zero.
  assign corr_r = sum_r[irnf_pkg::SUM_W-1] && (|sum_r[irnf_pkg::TRIG_FRAC_BITS-1:0]);
  assign corr_c = sum_c[irnf_pkg::SUM_W-1] && (|sum_c[irnf_pkg::TRIG_FRAC_BITS-1:0]);

  assign sr = irnf_pkg::SRC_W'(signed'(sum_r[irnf_pkg::SUM_W-1:irnf_pkg::TRIG_FRAC_BITS]))
            + signed'(irnf_pkg::SRC_W'(mr)) + signed'(irnf_pkg::SRC_W'(corr_r));
  assign sc = irnf_pkg::SRC_W'(signed'(sum_c[irnf_pkg::SUM_W-1:irnf_pkg::TRIG_FRAC_BITS]))
            + signed'(irnf_pkg::SRC_W'(mc)) + signed'(irnf_pkg::SRC_W'(corr_c));

  assign src_ok = !sr[irnf_pkg::SRC_W-1] && !sc[irnf_pkg::SRC_W-1]
               && (sr[irnf_pkg::SRC_W-2:0] < (irnf_pkg::SRC_W-1)'(rows_in_use))
               && (sc[irnf_pkg::SRC_W-2:0] < (irnf_pkg::SRC_W-1)'(cols_in_use));

  // Build the queue entry: stores keep their own address.
  always_comb begin
    entry_next.func = func3;
    entry_next.pix  = pix3;
    if (func3 == irnf_pkg::FUNC_STORE) begin
      entry_next.in_image = 1'b0;
      entry_next.addr     = {row3, col3};
    end else begin
      entry_next.in_image = in3 && src_ok;
      entry_next.addr     = {sr[irnf_pkg::ROW_W-1:0], sc[irnf_pkg::COL_W-1:0]};
    end
  end

  // Stage valids; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      push <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      push <= v3;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    func1 <= func;
    row1  <= row;
    col1  <= col;
    pix1  <= {pixel_red, pixel_green, pixel_blue};
    in1   <= in_next;
    dr1   <= dr_next;
    dc1   <= dc_next;

    func2 <= func1;
    row2  <= row1;
    col2  <= col1;
    pix2  <= pix1;
    in2   <= in1;
    p_cr  <= irnf_pkg::PROD_W'(cos_q) * irnf_pkg::PROD_W'(dr1);
    p_sc  <= irnf_pkg::PROD_W'(sin_q) * irnf_pkg::PROD_W'(dc1);
    p_cc  <= irnf_pkg::PROD_W'(cos_q) * irnf_pkg::PROD_W'(dc1);
    p_sr  <= irnf_pkg::PROD_W'(sin_q) * irnf_pkg::PROD_W'(dr1);

    func3 <= func2;
    row3  <= row2;
    col3  <= col2;
    pix3  <= pix2;
    in3   <= in2;
    sum_r <= irnf_pkg::SUM_W'(p_cr) + irnf_pkg::SUM_W'(p_sc);
    sum_c <= irnf_pkg::SUM_W'(p_cc) - irnf_pkg::SUM_W'(p_sr);

    push_entry <= entry_next;
  end

  // The queue must always have room for every word already in the pipeline.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    ((irnf_pkg::QLVL_W+1)'(q_level) + inflight)
      <= (irnf_pkg::QLVL_W+1)'(irnf_pkg::QDEPTH))
    else $error("front: queue credit exceeded");

endmodule

[rtl/irnf_queue.sv]
// Short FIFO of classified operations between the front and back ends.
// Flip-flop storage with a combinational head; uses irnf_pkg.
module irnf_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  irnf_pkg::irnf_entry_t        push_entry,
  input  logic                         pop,
  output irnf_pkg::irnf_entry_t        head,
  output logic                         head_valid,
  output logic [irnf_pkg::QLVL_W-1:0]  level
);

  irnf_pkg::irnf_entry_t         slots [irnf_pkg::QDEPTH];
  logic [irnf_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;

  assign head       = slots[rd_ptr];
  assign head_valid = (level != '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + irnf_pkg::QLVL_W'(push) - irnf_pkg::QLVL_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level != irnf_pkg::QLVL_W'(irnf_pkg::QDEPTH)) || pop)
    else $error("queue: push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue: pop from an empty queue");

endmodule

[rtl/irnf_back.sv]
// Back end: carries out stores and fetches against the frame memory.
// Holds the frame memory and the output register; uses irnf_pkg.
module irnf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  irnf_pkg::irnf_entry_t        head,
  input  logic                         head_valid,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [irnf_pkg::CH_W-1:0]    out_blue,
  output logic [irnf_pkg::CH_W-1:0]    out_green,
  output logic [irnf_pkg::CH_W-1:0]    out_red,
  output logic                         inside_res
);

  logic [irnf_pkg::PIX_W-1:0] frame_mem [irnf_pkg::MEM_DEPTH];
  logic [irnf_pkg::PIX_W-1:0] rd_data;
  logic                       is_store, is_fetch;

  assign is_store = (head.func == irnf_pkg::FUNC_STORE);
  assign is_fetch = (head.func == irnf_pkg::FUNC_FETCH);

  // Stores never wait; fetches wait for a free output register.
  assign pop = head_valid && (is_store || !out_valid || out_ready);

  // Frame memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (pop && is_store) begin
      frame_mem[head.addr] <= head.pix;
    end
    if (pop && is_fetch && head.in_image) begin
      rd_data <= frame_mem[head.addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      inside_res <= 1'b0;
    end else if (pop && is_fetch) begin
      out_valid  <= 1'b1;
      inside_res <= head.in_image;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  // Outside pixels read as black.
  assign out_blue  = inside_res ? rd_data[irnf_pkg::CH_W-1:0]              : '0;
  assign out_green = inside_res ? rd_data[2*irnf_pkg::CH_W-1:irnf_pkg::CH_W] : '0;
  assign out_red   = inside_res ? rd_data[3*irnf_pkg::CH_W-1:2*irnf_pkg::CH_W] : '0;

  a_fetch_delivers: assert property (@(posedge clk) disable iff (rst)
    (pop && is_fetch) |=> out_valid)
    else $error("back: fetch popped without a result");

endmodule

[rtl/image_rotation_nearest_fetch_unit.sv]
// Top level of the nearest-neighbor rotation fetch unit.
// Holds the configuration registers and joins irnf_front, irnf_queue, irnf_back.
//
// Usage: the input channel (in_valid/in_ready) takes one word per cycle. A
// word with func=0 stores one source pixel at (row, col); a word with func=1
// fetches output pixel (row, col), rotated about the image center with the
// Q1.16 cosine and sine registers. Each fetch returns exactly one word on the
// output channel (out_valid/out_ready); stores return nothing. Words are
// handled in order, so a fetch sees every store accepted before it.
// With the queue empty, a fetch word passes the four front stages, a queue
// slot and the output register. Throughput: one word per clock, set by the
// four-stage front pipeline and the separate write and read memory ports.
// When the receiver stalls, fetches back up in the 8-entry queue and in_ready
// drops once the queue plus the front pipeline would be full; stores queued
// ahead still retire. Configuration writes (cfg_valid/cfg_ready) are always
// ready and must be made while the block is idle. Reset restores the registers
// to a 512x512 image at zero angle and empties the pipeline and queue; the
// frame memory is not cleared and must be written before it is read.
module image_rotation_nearest_fetch_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irnf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irnf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [irnf_pkg::ROW_W-1:0]        row,
  input  logic [irnf_pkg::COL_W-1:0]        col,
  input  logic [irnf_pkg::CH_W-1:0]         pixel_blue,
  input  logic [irnf_pkg::CH_W-1:0]         pixel_green,
  input  logic [irnf_pkg::CH_W-1:0]         pixel_red,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [irnf_pkg::CH_W-1:0]         out_blue,
  output logic [irnf_pkg::CH_W-1:0]         out_green,
  output logic [irnf_pkg::CH_W-1:0]         out_red,
  output logic                              inside_res
);

  logic [irnf_pkg::DIM_W-1:0]          rows_in_use, cols_in_use;
  logic signed [irnf_pkg::TRIG_W-1:0]  cos_q, sin_q;
  logic [irnf_pkg::DIM_W-1:0]          dim_wr;
  logic [irnf_pkg::DIM_W-1:0]          dim_sat;

  logic                                push, pop, head_valid;
  irnf_pkg::irnf_entry_t               push_entry, head;
  logic [irnf_pkg::QLVL_W-1:0]         q_level;

  assign cfg_ready = 1'b1;

  // Dimensions saturate to the frame size.
  assign dim_wr  = cfg_data[irnf_pkg::DIM_W-1:0];
  assign dim_sat = (dim_wr > irnf_pkg::DIM_W'(irnf_pkg::MAX_ROWS))
                 ? irnf_pkg::DIM_W'(irnf_pkg::MAX_ROWS) : dim_wr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= irnf_pkg::ROWS_RESET;
      cols_in_use <= irnf_pkg::COLS_RESET;
      cos_q       <= irnf_pkg::COS_RESET;
      sin_q       <= irnf_pkg::SIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        irnf_pkg::REG_ROWS: rows_in_use <= dim_sat;
        irnf_pkg::REG_COLS: cols_in_use <= (dim_wr > irnf_pkg::DIM_W'(irnf_pkg::MAX_COLS))
                                         ? irnf_pkg::DIM_W'(irnf_pkg::MAX_COLS) : dim_wr;
        irnf_pkg::REG_COS:  cos_q <= signed'(cfg_data[irnf_pkg::TRIG_W-1:0]);
        irnf_pkg::REG_SIN:  sin_q <= signed'(cfg_data[irnf_pkg::TRIG_W-1:0]);
        default: ;
      endcase
    end
  end

  irnf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .row         (row),
    .col         (col),
    .pixel_blue  (pixel_blue),
    .pixel_green (pixel_green),
    .pixel_red   (pixel_red),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .cos_q       (cos_q),
    .sin_q       (sin_q),
    .q_level     (q_level),
    .push        (push),
    .push_entry  (push_entry)
  );

  irnf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  irnf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .inside_res (inside_res)
  );

endmodule
